// File: design/mkbm_pkg.sv
// Shared types, constants and keyword table for the multi-keyword byte matcher.
// No dependencies; mkbm_scan, the top level and the bench refer to this package by scoped names.

package mkbm_pkg;

    // default sizing, handed to the top level as parameter defaults
    localparam int NumKeywords = 15;
    localparam int KeywordLen  = 4;

    // fixed table geometry and field widths
    localparam int TableRows = 15;
    localparam int TableCols = 8;
    localparam int PosWidth  = 3;
    localparam int RowWidth  = 4;
    localparam int CodeWidth = 4;
    localparam int ByteWidth = 8;

    // keyword letters, first letter in the top byte, unused letters are zero
    localparam logic [TableCols*ByteWidth-1:0] KeywordTable [TableRows] = '{
        {"SPHY", 32'h0}, {"SHOW", 32'h0}, {"SCEN", 32'h0}, {"BLAC", 32'h0},
        {"UPDA", 32'h0}, {"BLOB", 32'h0}, {"TRIG", 32'h0}, {"QUEU", 32'h0},
        {"BRIG", 32'h0}, {"INTR", 32'h0}, {"DUMP", 32'h0}, {"DEBU", 32'h0},
        {"GETB", 32'h0}, {"SAVE", 32'h0}, {"LOAD", 32'h0}
    };

    // item modes
    typedef enum logic
    {
        MODE_MATCH = 1'b0,
        MODE_CLEAR = 1'b1
    } mode_t;

    // one registered input beat
    typedef struct packed
    {
        mode_t                mode;
        logic [ByteWidth-1:0] data_byte;
    } item_t;

    // code reported when no keyword completes
    localparam logic [CodeWidth-1:0] CodeNone = '0;

    // letter of a keyword at a given position
    function automatic logic [ByteWidth-1:0] key_char(
        input logic [RowWidth-1:0] row,
        input logic [PosWidth-1:0] col
    );
        logic [5:0] base;
        base = {~col, 3'b000};
        return KeywordTable[row][base +: ByteWidth];
    endfunction

endpackage

// File: design/mkbm_in_if.sv
// Input channel of the keyword matcher: valid/ready handshake with mode and byte.
// Depends on nothing.

interface mkbm_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// File: design/mkbm_out_if.sv
// Result channel of the keyword matcher: valid/ready handshake with the match code.
// Depends on nothing.

interface mkbm_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] hit_code;

    modport source (output valid, output hit_code, input ready);
    modport sink   (input valid, input hit_code, output ready);
endinterface

// File: design/mkbm_scan.sv
// Combinational keyword scan: compares one byte against the keyword positions in table order,
// picks the first completed keyword and forms the next positions; a clear beat zeroes them. Uses mkbm_pkg.

module mkbm_scan #(
    parameter int NUM_KEYWORDS = mkbm_pkg::NumKeywords,
    parameter int KEYWORD_LEN  = mkbm_pkg::KeywordLen
) (
    input  mkbm_pkg::item_t                                      item,
    input  logic [NUM_KEYWORDS-1:0][mkbm_pkg::PosWidth-1:0]      pos,
    output logic [NUM_KEYWORDS-1:0][mkbm_pkg::PosWidth-1:0]      pos_next,
    output logic [mkbm_pkg::CodeWidth-1:0]                       hit_code
);

    localparam logic [mkbm_pkg::PosWidth-1:0] LenPos = mkbm_pkg::PosWidth'(KEYWORD_LEN);

    // per-keyword update in table order, later keywords frozen after a hit
    always_comb
    begin
        logic blocked;
        blocked  = 1'b0;
        hit_code = mkbm_pkg::CodeNone;
        pos_next = pos;
        if (item.mode == mkbm_pkg::MODE_CLEAR)
        begin
            pos_next = '0;
        end
        else
        begin
            for (int k = 0; k < NUM_KEYWORDS; k++)
            begin
                if (!blocked)
                begin
                    if (pos[k] >= LenPos)
                    begin
                        // completed keyword restarts, byte not rechecked
                        pos_next[k] = '0;
                    end
                    else if (item.data_byte ==
                             mkbm_pkg::key_char(mkbm_pkg::RowWidth'(k), pos[k]))
                    begin
                        pos_next[k] = pos[k] + 3'd1;
                        if ((pos[k] + 3'd1) == LenPos)
                        begin
                            hit_code = mkbm_pkg::CodeWidth'(k + 1);
                            blocked  = 1'b1;
                        end
                    end
                    else
                    begin
                        pos_next[k] = '0;
                    end
                end
            end
        end
    end

endmodule

// File: design/multi_keyword_byte_matcher.sv
// Multi-keyword byte matcher top level: input register, keyword scan, result register.
// Depends on mkbm_pkg, mkbm_in_if, mkbm_out_if and mkbm_scan.
//
// The block takes one byte per beat and tracks every command keyword at once,
// one position counter per keyword. A byte that completes a keyword returns
// that keyword's code (1 for the first table entry), and keywords later in
// the table keep their positions for that byte; otherwise the code is 0. A
// beat with mode set clears all positions and returns code 0. Each beat
// gives exactly one result. Throughput is one beat per clock while the
// receiver holds result ready: the byte is registered, all comparators and
// the priority pick run on the registered byte against the position
// registers, and the code lands in the output register. The output
// register and the input register let a new beat enter while a finished
// result still waits on the output side.

module multi_keyword_byte_matcher #(
    parameter int NUM_KEYWORDS = mkbm_pkg::NumKeywords,
    parameter int KEYWORD_LEN  = mkbm_pkg::KeywordLen
) (
    input logic        clk,
    input logic        rst_n,
    mkbm_in_if.sink    cmd,
    mkbm_out_if.source result
);

    localparam logic [mkbm_pkg::PosWidth-1:0] LenPos = mkbm_pkg::PosWidth'(KEYWORD_LEN);

    logic                                                s1_valid_reg;
    mkbm_pkg::item_t                                     s1_item_reg;
    logic [NUM_KEYWORDS-1:0][mkbm_pkg::PosWidth-1:0]     pos_reg;
    logic [NUM_KEYWORDS-1:0][mkbm_pkg::PosWidth-1:0]     pos_next;
    logic                                                out_valid_reg;
    logic [mkbm_pkg::CodeWidth-1:0]                      out_code_reg;
    logic [mkbm_pkg::CodeWidth-1:0]                      out_code_next;
    logic                                                s1_adv;
    logic                                                in_take;
    logic                                                pos_over;

    // handshake control
    assign s1_adv  = s1_valid_reg && (!out_valid_reg || result.ready);
    assign in_take = cmd.valid && cmd.ready;

    assign cmd.ready       = !s1_valid_reg || s1_adv;
    assign result.valid    = out_valid_reg;
    assign result.hit_code = out_code_reg;

    // keyword scan on the registered beat
    mkbm_scan #(
        .NUM_KEYWORDS (NUM_KEYWORDS),
        .KEYWORD_LEN  (KEYWORD_LEN)
    ) u_scan (
        .item     (s1_item_reg),
        .pos      (pos_reg),
        .pos_next (pos_next),
        .hit_code (out_code_next)
    );

    // control state: stage valids and keyword positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.mode      <= mkbm_pkg::mode_t'(cmd.mode);
            s1_item_reg.data_byte <= cmd.data_byte;
        end
        if (s1_adv)
        begin
            out_code_reg <= out_code_next;
        end
    end

    // any position past the keyword length
    always_comb
    begin
        pos_over = 1'b0;
        for (int k = 0; k < NUM_KEYWORDS; k++)
        begin
            if (pos_reg[k] > LenPos)
            begin
                pos_over = 1'b1;
            end
        end
    end

    // checks
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n) !pos_over)
        else $error("keyword position beyond keyword length");

    a_clear_positions: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_item_reg.mode == mkbm_pkg::MODE_CLEAR) |=> (pos_reg == '0))
        else $error("clear beat left a keyword position set");

    a_clear_code: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_item_reg.mode == mkbm_pkg::MODE_CLEAR)
        |=> out_valid_reg && (out_code_reg == mkbm_pkg::CodeNone))
        else $error("clear beat produced a nonzero code");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_code_reg <= mkbm_pkg::CodeWidth'(NUM_KEYWORDS)))
        else $error("match code beyond keyword count");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_code_reg))
        else $error("stalled result dropped or changed");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for multi_keyword_byte_matcher: directed table, then random streams.
// Depends on mkbm_pkg, mkbm_in_if, mkbm_out_if and the matcher RTL.
// Keyword tracking is predicted in the bench and every result is compared in order.

module tb_top;

    localparam int KW_COUNT   = mkbm_pkg::NumKeywords;
    localparam int KW_LEN     = mkbm_pkg::KeywordLen;
    localparam int PHASE_BEATS = 213;
    localparam int CYCLE_LIMIT = 200000;

    // all keywords back to back, four letters each, first keyword leftmost
    localparam logic [8*60-1:0] KEYWORD_TEXT =
        "SPHYSHOWSCENBLACUPDABLOBTRIGQUEUBRIGINTRDUMPDEBUGETBSAVELOAD";

    // one row of the directed table; has_code marks a hand-written result
    typedef struct packed
    {
        mkbm_pkg::mode_t mode;
        logic [7:0]      data_byte;
        logic            has_code;
        logic [3:0]      code;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{mkbm_pkg::MODE_MATCH, 8'h00, 1'b1, 4'd0},   // zero byte after reset
        '{mkbm_pkg::MODE_MATCH, 8'hFF, 1'b1, 4'd0},   // all-ones byte
        '{mkbm_pkg::MODE_CLEAR, 8'hA5, 1'b1, 4'd0},   // clear with junk byte
        '{mkbm_pkg::MODE_MATCH, "S",   1'b1, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "P",   1'b1, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "H",   1'b1, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "Y",   1'b1, 4'd1},   // first table entry completes
        '{mkbm_pkg::MODE_MATCH, "Y",   1'b0, 4'd0},   // completed keyword restarts
        '{mkbm_pkg::MODE_CLEAR, 8'h00, 1'b1, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "L",   1'b1, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "O",   1'b1, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "A",   1'b1, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "D",   1'b1, 4'd15},  // last table entry completes
        '{mkbm_pkg::MODE_MATCH, "G",   1'b0, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "E",   1'b0, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "T",   1'b0, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "B",   1'b0, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "S",   1'b0, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "C",   1'b0, 4'd0},
        '{mkbm_pkg::MODE_CLEAR, 8'h5A, 1'b1, 4'd0},   // clear in the middle of a keyword
        '{mkbm_pkg::MODE_MATCH, "E",   1'b0, 4'd0},
        '{mkbm_pkg::MODE_MATCH, "N",   1'b0, 4'd0},
        '{mkbm_pkg::MODE_CLEAR, 8'hFF, 1'b1, 4'd0}
    };

    logic clk;
    logic rst_n;

    mkbm_in_if  cmd_bus ();
    mkbm_out_if result_bus ();

    multi_keyword_byte_matcher i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .result (result_bus)
    );

    // bench copy of the per-keyword position counters
    logic [2:0] kw_pos [KW_COUNT];

    // codes still owed by the block, oldest first
    logic [3:0] pending_codes [$];

    int unsigned errors;
    int unsigned beats_sent;
    int unsigned results_checked;
    int unsigned keyword_hits;
    int unsigned clears_sent;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned stall_pct;

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // letter p of keyword k
    function automatic logic [7:0] keyword_letter(input int k, input int p);
        return KEYWORD_TEXT[8*(59 - (4*k + p)) +: 8];
    endfunction

    // step all keyword counters by one beat and return the code it yields
    function automatic logic [3:0] advance_keywords(input mkbm_pkg::mode_t mode,
                                                    input logic [7:0] b);
        logic [3:0] code;
        logic       done;
        int         k;
        code = mkbm_pkg::CodeNone;
        done = 1'b0;
        if (mode == mkbm_pkg::MODE_CLEAR)
        begin
            for (k = 0; k < KW_COUNT; k++)
                kw_pos[k] = '0;
            return code;
        end
        for (k = 0; k < KW_COUNT && !done; k++)
        begin
            if (kw_pos[k] >= KW_LEN)
                kw_pos[k] = '0;
            else if (b == keyword_letter(k, kw_pos[k]))
            begin
                kw_pos[k] = kw_pos[k] + 3'd1;
                if (kw_pos[k] >= KW_LEN)
                begin
                    code = 4'(k + 1);
                    done = 1'b1;
                end
            end
            else
                kw_pos[k] = '0;
        end
        return code;
    endfunction

    // offer one beat, with an optional idle gap first, and log its code on acceptance
    task automatic send_beat(input mkbm_pkg::mode_t mode, input logic [7:0] b,
                             input logic has_code, input logic [3:0] code);
        logic [3:0] predicted;
        int unsigned gap;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(4, 1);
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.mode      <= mode;
        cmd_bus.data_byte <= b;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predicted = advance_keywords(mode, b);
        pending_codes.push_back(has_code ? code : predicted);
        beats_sent++;
        if (mode == mkbm_pkg::MODE_CLEAR)
            clears_sent++;
    endtask

    // send the first n letters of keyword k
    task automatic send_keyword(input int k, input int n);
        int p;
        for (p = 0; p < n; p++)
            send_beat(mkbm_pkg::MODE_MATCH, keyword_letter(k, p), 1'b0, mkbm_pkg::CodeNone);
    endtask

    // hold the sender off until every owed result has come back
    task automatic wait_drain();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_codes.size() != 0)
            @(posedge clk);
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        result_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_codes.size() == 0)
            begin
                $display("%0t: unexpected result, actual code %0d", $time,
                         result_bus.hit_code);
                errors++;
            end
            else
            begin
                if (result_bus.hit_code !== pending_codes[0])
                begin
                    $display("%0t: hit_code mismatch, expected %0d actual %0d", $time,
                             pending_codes[0], result_bus.hit_code);
                    errors++;
                end
                void'(pending_codes.pop_front());
                results_checked++;
                if (result_bus.hit_code != mkbm_pkg::CodeNone)
                    keyword_hits++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multi_keyword_byte_matcher test failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int i;
        int phase;
        int start_beats;
        int pick;
        int k;
        rst_n             = 1'b0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.mode      = mkbm_pkg::MODE_MATCH;
        cmd_bus.data_byte = '0;
        result_bus.ready  = 1'b0;
        errors            = 0;
        beats_sent        = 0;
        results_checked   = 0;
        keyword_hits      = 0;
        clears_sent       = 0;
        cycle_count       = 0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        for (i = 0; i < KW_COUNT; i++)
            kw_pos[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < DIRECTED_ROWS; i++)
            send_beat(DIRECTED[i].mode, DIRECTED[i].data_byte,
                      DIRECTED[i].has_code, DIRECTED[i].code);

        // random streams over four idling phases
        for (phase = 0; phase < 4; phase++)
        begin
            wait_drain();
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 65; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 65; end
                default: begin send_idle_pct = 18; stall_pct <= 18; end
            endcase
            start_beats = beats_sent;
            while (beats_sent - start_beats < PHASE_BEATS)
            begin
                pick = $urandom_range(99);
                k    = $urandom_range(KW_COUNT - 1);
                if (pick < 55)
                    send_keyword(k, KW_LEN);
                else if (pick < 70)
                    send_keyword(k, $urandom_range(KW_LEN - 1, 1));
                else if (pick < 82)
                    send_beat(mkbm_pkg::MODE_MATCH,
                              keyword_letter(k, $urandom_range(KW_LEN - 1)),
                              1'b0, mkbm_pkg::CodeNone);
                else if (pick < 92)
                    send_beat(mkbm_pkg::MODE_MATCH, 8'($urandom_range(255)),
                              1'b0, mkbm_pkg::CodeNone);
                else if (pick < 98)
                    send_beat(mkbm_pkg::MODE_CLEAR, 8'($urandom_range(255)),
                              1'b0, mkbm_pkg::CodeNone);
                else
                    wait_drain();
            end
        end

        // drain and let the pipeline settle
        wait_drain();
        repeat (8) @(posedge clk);

        $display("sent %0d beats (%0d clears), checked %0d results, %0d keyword hits",
                 beats_sent, clears_sent, results_checked, keyword_hits);
        if (errors == 0 && pending_codes.size() == 0)
            $display("multi_keyword_byte_matcher test passed");
        else
            $display("multi_keyword_byte_matcher test failed");
        $finish;
    end

endmodule

// File: multi_keyword_byte_matcher.f
design/mkbm_pkg.sv
design/mkbm_in_if.sv
design/mkbm_out_if.sv
design/mkbm_scan.sv
design/multi_keyword_byte_matcher.sv
tb/tb_top.sv
